FILE: hw/rtl/fes_pkg.sv
// Package for the fault escalation supervisor: types, codes, fault tables and helpers.
package fes_pkg;

    localparam int COMPONENTS   = 7;
    localparam int COMP_BITS    = $clog2(COMPONENTS);
    localparam int TIME_BITS    = 48;
    localparam int COUNT_BITS   = 32;
    localparam int CODE_BITS    = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 32;
    localparam int TMO_BITS     = 32;
    localparam int THR_BITS     = 16;
    localparam int OUT_CNT_BITS = 32;

    localparam logic [TMO_BITS-1:0] CAMERA_TIMEOUT_RST = TMO_BITS'(1000000);
    localparam logic [TMO_BITS-1:0] SINK_TIMEOUT_RST   = TMO_BITS'(1000000);
    localparam logic [THR_BITS-1:0] EVAL_COUNT_RST     = THR_BITS'(3);
    localparam logic [THR_BITS-1:0] DEBUG_COUNT_RST    = THR_BITS'(3);

    typedef enum logic [1:0] {
        H_HEALTHY  = 2'd0,
        H_DEGRADED = 2'd1,
        H_FAILED   = 2'd2
    } t_health;

    typedef enum logic [2:0] {
        A_CONTINUE  = 3'd0,
        A_SKIP      = 3'd1,
        A_DISABLE   = 3'd2,
        A_STOP      = 3'd3,
        A_TERM      = 3'd4,
        A_STOP_TERM = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        TERM_NONE     = 2'd0,
        TERM_CAMERA   = 2'd1,
        TERM_PIPELINE = 2'd2,
        TERM_CONTROL  = 2'd3
    } t_term;

    typedef enum logic {
        CMD_REPORT  = 1'b0,
        CMD_RECOVER = 1'b1
    } t_cmd;

    typedef enum logic [CODE_BITS-1:0] {
        FC_CAM_TIMEOUT     = 4'd0,
        FC_CAM_INVALID     = 4'd1,
        FC_CAM_DISCONNECT  = 4'd2,
        FC_CAM_FATAL       = 4'd3,
        FC_PIPE_EXC        = 4'd4,
        FC_CTRL_UPDATE_EXC = 4'd5,
        FC_CTRL_THREAD_EXC = 4'd6,
        FC_SINK_UNHEALTHY  = 4'd7,
        FC_SEND_FAILED     = 4'd8,
        FC_EVAL_INIT       = 4'd9,
        FC_EVAL_EXC        = 4'd10,
        FC_DEBUG_INIT      = 4'd11,
        FC_DEBUG_EXC       = 4'd12,
        FC_DIAG_A          = 4'd13,
        FC_DIAG_B          = 4'd14,
        FC_DIAG_C          = 4'd15
    } t_fault;

    typedef logic [COMP_BITS-1:0] t_comp;
    localparam t_comp COMP_CAMERA   = t_comp'(0);
    localparam t_comp COMP_PIPELINE = t_comp'(1);
    localparam t_comp COMP_CONTROL  = t_comp'(2);
    localparam t_comp COMP_SINK     = t_comp'(3);
    localparam t_comp COMP_EVAL     = t_comp'(4);
    localparam t_comp COMP_DEBUG    = t_comp'(5);
    localparam t_comp COMP_DIAG     = t_comp'(6);
    localparam t_comp COMP_NONE     = t_comp'(7);

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CAMERA_TIMEOUT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SINK_TIMEOUT   = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_EVAL_COUNT     = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_DEBUG_COUNT    = t_cfg_idx'(3);

    typedef struct packed {
        logic                 cmd;
        logic [CODE_BITS-1:0] fault_code;
        logic [2:0]           target_component;
        logic [TIME_BITS-1:0] now_time;
    } t_fes_in;

    typedef struct packed {
        logic [1:0]              decision_state;
        logic                    skip_work;
        logic                    disable_unit;
        logic                    stop_req;
        logic [1:0]              termination;
        logic [OUT_CNT_BITS-1:0] consecutive_count;
        logic [1:0]              overall_state;
        logic [1:0]              terminal_reason;
    } t_fes_out;

    // one component record as held in the state memory
    typedef struct packed {
        t_health               health;
        logic                  seen_healthy;
        logic [TIME_BITS-1:0]  ok_time;
        logic [TIME_BITS-1:0]  first_time;
        logic [COUNT_BITS-1:0] consecutive;
        logic [COUNT_BITS-1:0] total;
    } t_rec;

    function automatic t_comp code_comp(input logic [CODE_BITS-1:0] code);
        t_comp c;
        unique case (t_fault'(code))
            FC_CAM_TIMEOUT, FC_CAM_INVALID,
            FC_CAM_DISCONNECT, FC_CAM_FATAL:        c = COMP_CAMERA;
            FC_PIPE_EXC:                            c = COMP_PIPELINE;
            FC_CTRL_UPDATE_EXC, FC_CTRL_THREAD_EXC: c = COMP_CONTROL;
            FC_SINK_UNHEALTHY, FC_SEND_FAILED:      c = COMP_SINK;
            FC_EVAL_INIT, FC_EVAL_EXC:              c = COMP_EVAL;
            FC_DEBUG_INIT, FC_DEBUG_EXC:            c = COMP_DEBUG;
            default:                                c = COMP_DIAG;
        endcase
        return c;
    endfunction

    function automatic t_action code_act(input logic [CODE_BITS-1:0] code);
        t_action a;
        unique case (t_fault'(code))
            FC_CAM_TIMEOUT, FC_CAM_INVALID, FC_EVAL_INIT, FC_EVAL_EXC,
            FC_DEBUG_INIT, FC_DEBUG_EXC:            a = A_SKIP;
            FC_CAM_DISCONNECT, FC_CAM_FATAL, FC_PIPE_EXC,
            FC_CTRL_UPDATE_EXC, FC_CTRL_THREAD_EXC: a = A_STOP_TERM;
            FC_SINK_UNHEALTHY, FC_SEND_FAILED:      a = A_STOP;
            default:                                a = A_CONTINUE;
        endcase
        return a;
    endfunction

    function automatic t_term code_term(input logic [CODE_BITS-1:0] code);
        t_term t;
        unique case (t_fault'(code))
            FC_CAM_DISCONNECT, FC_CAM_FATAL:        t = TERM_CAMERA;
            FC_PIPE_EXC:                            t = TERM_PIPELINE;
            FC_CTRL_UPDATE_EXC, FC_CTRL_THREAD_EXC: t = TERM_CONTROL;
            default:                                t = TERM_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

FILE: hw/rtl/fault_escalation_supervisor.sv
// Fault escalation supervisor top level: state memory, read-modify-write sequencer, output beat.
//
// Each beat is a report or a recover for one of seven components. The block takes one beat at a
// time, stalling the next until the last is written back: capture, read of the component record
// from the state memory, count and elapsed-time stage, then decision and write-back into the
// memory and the output register. The result beat waits in the output register; a later beat's
// write-back waits while an earlier result is still stalled. Per-entry valid bits stand in for a
// cleared memory, so there is no clearing pass after reset. The configuration port is ready
// whenever reset is released; write it only while the block is idle.
module fault_escalation_supervisor import fes_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_fes_in         i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_fes_out        o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  t_cfg_idx        i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_WB
    } t_state;

    localparam int CMP_BITS = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

    t_state                 r_state;
    t_fes_in                r_in;
    t_comp                  r_addr;
    logic                   r_hit;
    logic                   r_rd_vld;
    t_rec                   r_rd;
    t_rec                   r_mem [COMPONENTS];
    logic [COMPONENTS-1:0]  r_vld;
    logic [COMPONENTS-1:0]  r_active;
    logic                   r_term_valid;
    t_term                  r_term_reason;
    logic [TMO_BITS-1:0]    r_camera_timeout;
    logic [TMO_BITS-1:0]    r_sink_timeout;
    logic [THR_BITS-1:0]    r_eval_count;
    logic [THR_BITS-1:0]    r_debug_count;
    logic                   r_entering;
    logic [TIME_BITS-1:0]   r_diff;
    logic [COUNT_BITS-1:0]  r_consec;
    logic [COUNT_BITS-1:0]  r_total;
    logic                   r_out_valid;
    t_fes_out               r_out;

    t_rec                   w_cur;
    logic                   w_is_report;
    logic                   w_entering;
    logic [TIME_BITS-1:0]   w_start;
    logic                   w_out_free;
    logic                   w_we;
    t_action                w_act;

    t_rec                   n_rec;
    logic [COMPONENTS-1:0]  n_active;
    logic                   n_term_valid;
    t_term                  n_term_reason;
    logic [TIME_BITS-1:0]   n_diff;
    logic [COUNT_BITS-1:0]  n_consec;
    t_fes_out               n_out;

    t_health                h_next;
    t_term                  term;
    logic                   skip;
    logic                   dis;
    logic                   stop;
    logic [COUNT_BITS-1:0]  consec_out;

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_cur       = r_rd_vld ? r_rd : '0;
    assign w_is_report = (r_in.cmd == CMD_REPORT);
    assign w_entering  = !r_active[r_addr];
    assign w_act       = code_act(r_in.fault_code);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_we        = (r_state == S_WB) && w_out_free && r_hit;

    // elapsed time since the last healthy observation, else since first seen
    assign w_start  = w_cur.seen_healthy ? w_cur.ok_time
                    : (w_entering ? r_in.now_time : w_cur.first_time);
    assign n_diff   = r_in.now_time - w_start;
    assign n_consec = w_entering ? COUNT_BITS'(1) : sat_inc(w_cur.consecutive);

    always_comb begin
        n_rec      = w_cur;
        n_active   = r_active;
        h_next     = H_HEALTHY;
        term       = TERM_NONE;
        skip       = 1'b0;
        dis        = 1'b0;
        stop       = 1'b0;
        consec_out = '0;
        if (w_is_report) begin
            skip   = (w_act == A_SKIP);
            stop   = (w_act == A_STOP) || (w_act == A_STOP_TERM);
            term   = code_term(r_in.fault_code);
            h_next = r_entering ? H_DEGRADED : w_cur.health;
            priority if (r_addr == COMP_CAMERA && term == TERM_NONE) begin
                if (r_diff >= TIME_BITS'(r_camera_timeout)) begin
                    stop = 1'b1;
                    term = TERM_CAMERA;
                end
            end else if (r_addr == COMP_SINK) begin
                if (r_diff >= TIME_BITS'(r_sink_timeout)) begin
                    stop = 1'b1;
                    term = TERM_CONTROL;
                end
            end else if (r_addr == COMP_EVAL) begin
                skip = 1'b1;
                dis  = (t_fault'(r_in.fault_code) == FC_EVAL_INIT)
                    || (CMP_BITS'(r_consec) == CMP_BITS'(r_eval_count));
            end else if (r_addr == COMP_DEBUG) begin
                skip = 1'b1;
                dis  = (t_fault'(r_in.fault_code) == FC_DEBUG_INIT)
                    || (CMP_BITS'(r_consec) == CMP_BITS'(r_debug_count));
            end else begin
                skip = skip;
            end
            if (term != TERM_NONE) begin
                h_next = H_FAILED;
            end
            n_rec.health      = h_next;
            n_rec.first_time  = r_entering ? r_in.now_time : w_cur.first_time;
            n_rec.consecutive = r_consec;
            n_rec.total       = r_total;
            n_active[r_addr]  = 1'b1;
            consec_out        = r_consec;
        end else if (r_hit) begin
            n_rec.seen_healthy = 1'b1;
            n_rec.ok_time      = r_in.now_time;
            h_next             = w_cur.health;
            if (r_active[r_addr] && w_cur.health != H_FAILED) begin
                n_active[r_addr] = 1'b0;
                h_next           = H_HEALTHY;
            end
            n_rec.health = h_next;
            consec_out   = n_active[r_addr] ? w_cur.consecutive : '0;
        end

        n_term_valid  = r_term_valid || (term != TERM_NONE);
        n_term_reason = r_term_valid ? r_term_reason : term;

        n_out.decision_state    = h_next;
        n_out.skip_work         = skip;
        n_out.disable_unit      = dis;
        n_out.stop_req          = stop;
        n_out.termination       = term;
        n_out.consecutive_count = OUT_CNT_BITS'(consec_out);
        n_out.overall_state     = n_term_valid ? H_FAILED
                                : ((|n_active) ? H_DEGRADED : H_HEALTHY);
        n_out.terminal_reason   = n_term_reason;
    end

    // component record memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_hit) begin
            r_rd <= r_mem[r_addr];
        end
        if (w_we) begin
            r_mem[r_addr] <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_out_valid      <= 1'b0;
            r_vld            <= '0;
            r_active         <= '0;
            r_term_valid     <= 1'b0;
            r_term_reason    <= TERM_NONE;
            r_rd_vld         <= 1'b0;
            r_camera_timeout <= CAMERA_TIMEOUT_RST;
            r_sink_timeout   <= SINK_TIMEOUT_RST;
            r_eval_count     <= EVAL_COUNT_RST;
            r_debug_count    <= DEBUG_COUNT_RST;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CAMERA_TIMEOUT: r_camera_timeout <= TMO_BITS'(i_cfg_data);
                    CFG_SINK_TIMEOUT:   r_sink_timeout   <= TMO_BITS'(i_cfg_data);
                    CFG_EVAL_COUNT:     r_eval_count     <= i_cfg_data[THR_BITS-1:0];
                    CFG_DEBUG_COUNT:    r_debug_count    <= i_cfg_data[THR_BITS-1:0];
                    default:            r_debug_count    <= r_debug_count;
                endcase
            end

            // a write-back in the same cycle reloads the output register instead
            if (r_out_valid && !i_out_stall && r_state != S_WB) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_addr  <= (i_in_data.cmd == CMD_REPORT)
                                 ? code_comp(i_in_data.fault_code)
                                 : t_comp'(i_in_data.target_component);
                        r_hit   <= (i_in_data.cmd == CMD_REPORT)
                                || (t_comp'(i_in_data.target_component) != COMP_NONE);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_vld <= r_hit && r_vld[r_addr];
                    r_state  <= S_EXEC;
                end
                S_EXEC: begin
                    r_entering <= w_entering;
                    r_diff     <= n_diff;
                    r_consec   <= n_consec;
                    r_total    <= sat_inc(w_cur.total);
                    r_state    <= S_WB;
                end
                S_WB: begin
                    if (w_out_free) begin
                        if (r_hit) begin
                            r_vld[r_addr] <= 1'b1;
                        end
                        r_active      <= n_active;
                        r_term_valid  <= n_term_valid;
                        r_term_reason <= n_term_reason;
                        r_out         <= n_out;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: bench/tb_fault_escalation_supervisor.sv
// Testbench for the fault escalation supervisor: directed table, random phases, predictor check.
`timescale 1ns / 1ps

module tb_fault_escalation_supervisor import fes_pkg::*; ();

    localparam int CYCLE_NS   = 12;
    localparam int LIMIT_CYC  = 400000;
    localparam int PHASE_LEN  = 460;
    localparam int HOLD_LEN   = 400;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_fes_in             i_in_data   = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    t_cfg_idx            i_cfg_index = CFG_CAMERA_TIMEOUT;
    logic [CFG_BITS-1:0] i_cfg_data  = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_fes_out            o_out_data;
    logic                o_cfg_ready;

    fault_escalation_supervisor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CYCLE_NS / 2) i_clk = 1'b1;
        #(CYCLE_NS / 2) i_clk = 1'b0;
    end

    // supervisor state as the bench sees it
    t_health               m_health [COMPONENTS];
    logic [COMPONENTS-1:0] m_active;
    logic [COMPONENTS-1:0] m_seen;
    logic [TIME_BITS-1:0]  m_last   [COMPONENTS];
    logic [TIME_BITS-1:0]  m_first  [COMPONENTS];
    logic [COUNT_BITS-1:0] m_consec [COMPONENTS];
    logic [COUNT_BITS-1:0] m_total  [COMPONENTS];
    logic                  m_term_valid;
    t_comp                 m_term_comp;

    logic [TMO_BITS-1:0]   cam_tmo  = CAMERA_TIMEOUT_RST;
    logic [TMO_BITS-1:0]   sink_tmo = SINK_TIMEOUT_RST;
    logic [THR_BITS-1:0]   eval_thr = EVAL_COUNT_RST;
    logic [THR_BITS-1:0]   dbg_thr  = DEBUG_COUNT_RST;

    t_fes_out verdict_q [$];

    typedef struct {
        t_fes_in  beat;
        bit       typed;
        t_fes_out want;
    } t_row;
    t_row plan [$];

    int          n_errors  = 0;
    int          n_beats   = 0;
    int          n_checked = 0;
    int          n_terms   = 0;
    int          n_disable = 0;
    int          snd_idle  = 24;
    int          rcv_idle  = 63;
    int          hold_reqs = 0;
    logic [TIME_BITS-1:0] tick = '0;
    logic [CODE_BITS-1:0] last_code = '0;

    initial begin
        foreach (m_health[i]) begin
            m_health[i] = H_HEALTHY;
            m_last[i]   = '0;
            m_first[i]  = '0;
            m_consec[i] = '0;
            m_total[i]  = '0;
        end
        m_active     = '0;
        m_seen       = '0;
        m_term_valid = 1'b0;
        m_term_comp  = COMP_CAMERA;
    end

    function automatic logic [COUNT_BITS-1:0] sat_bump(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic void fault_map(input logic [CODE_BITS-1:0] code, output t_comp c,
                                      output t_action a, output t_term t);
        t = TERM_NONE;
        case (t_fault'(code))
            FC_CAM_TIMEOUT, FC_CAM_INVALID: begin
                c = COMP_CAMERA;
                a = A_SKIP;
            end
            FC_CAM_DISCONNECT, FC_CAM_FATAL: begin
                c = COMP_CAMERA;
                a = A_STOP_TERM;
                t = TERM_CAMERA;
            end
            FC_PIPE_EXC: begin
                c = COMP_PIPELINE;
                a = A_STOP_TERM;
                t = TERM_PIPELINE;
            end
            FC_CTRL_UPDATE_EXC, FC_CTRL_THREAD_EXC: begin
                c = COMP_CONTROL;
                a = A_STOP_TERM;
                t = TERM_CONTROL;
            end
            FC_SINK_UNHEALTHY, FC_SEND_FAILED: begin
                c = COMP_SINK;
                a = A_STOP;
            end
            FC_EVAL_INIT, FC_EVAL_EXC: begin
                c = COMP_EVAL;
                a = A_SKIP;
            end
            FC_DEBUG_INIT, FC_DEBUG_EXC: begin
                c = COMP_DEBUG;
                a = A_SKIP;
            end
            default: begin
                c = COMP_DIAG;
                a = A_CONTINUE;
            end
        endcase
    endfunction

    // wraps modulo 2^TIME_BITS
    function automatic logic [TIME_BITS-1:0] since_healthy(input t_comp c,
                                                           input logic [TIME_BITS-1:0] now);
        return now - (m_seen[c] ? m_last[c] : m_first[c]);
    endfunction

    function automatic t_fes_out next_verdict(input t_fes_in b);
        t_fes_out r;
        t_comp    c;
        t_action  act;
        t_term    tm;
        logic     skip;
        logic     dis;
        logic     stop;
        r = '0;
        if (t_cmd'(b.cmd) == CMD_REPORT) begin
            fault_map(b.fault_code, c, act, tm);
            m_total[c] = sat_bump(m_total[c]);
            if (!m_active[c]) begin
                m_active[c] = 1'b1;
                m_health[c] = H_DEGRADED;
                m_consec[c] = COUNT_BITS'(1);
                m_first[c]  = b.now_time;
            end else begin
                m_consec[c] = sat_bump(m_consec[c]);
            end
            skip = (act == A_SKIP);
            stop = (act == A_STOP) || (act == A_STOP_TERM);
            dis  = 1'b0;
            if (c == COMP_CAMERA && tm == TERM_NONE) begin
                if (since_healthy(c, b.now_time) >= TIME_BITS'(cam_tmo)) begin
                    stop = 1'b1;
                    tm   = TERM_CAMERA;
                end
            end else if (c == COMP_SINK) begin
                if (since_healthy(c, b.now_time) >= TIME_BITS'(sink_tmo)) begin
                    stop = 1'b1;
                    tm   = TERM_CONTROL;
                end
            end else if (c == COMP_EVAL) begin
                skip = 1'b1;
                dis  = (t_fault'(b.fault_code) == FC_EVAL_INIT) ||
                       (m_consec[c] == COUNT_BITS'(eval_thr));
            end else if (c == COMP_DEBUG) begin
                skip = 1'b1;
                dis  = (t_fault'(b.fault_code) == FC_DEBUG_INIT) ||
                       (m_consec[c] == COUNT_BITS'(dbg_thr));
            end
            if (tm != TERM_NONE) begin
                m_health[c] = H_FAILED;
                if (!m_term_valid) begin
                    m_term_valid = 1'b1;
                    m_term_comp  = c;
                end
            end
            r.decision_state    = m_health[c];
            r.skip_work         = skip;
            r.disable_unit      = dis;
            r.stop_req          = stop;
            r.termination       = tm;
            r.consecutive_count = m_consec[c];
        end else if (b.target_component < COMPONENTS) begin
            c = t_comp'(b.target_component);
            m_seen[c] = 1'b1;
            m_last[c] = b.now_time;
            if (m_active[c] && m_health[c] != H_FAILED) begin
                m_active[c] = 1'b0;
                m_health[c] = H_HEALTHY;
            end
            r.decision_state    = m_health[c];
            r.consecutive_count = m_active[c] ? m_consec[c] : '0;
        end
        r.overall_state = m_term_valid ? H_FAILED : ((|m_active) ? H_DEGRADED : H_HEALTHY);
        if (m_term_valid) begin
            case (m_term_comp)
                COMP_CAMERA:             r.terminal_reason = TERM_CAMERA;
                COMP_PIPELINE:           r.terminal_reason = TERM_PIPELINE;
                COMP_CONTROL, COMP_SINK: r.terminal_reason = TERM_CONTROL;
                default:                 r.terminal_reason = TERM_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic t_fes_out mk_out(input t_health st, input logic sk, input logic ds,
                                        input logic sp, input t_term tm,
                                        input logic [OUT_CNT_BITS-1:0] cn,
                                        input t_health ov, input t_term rs);
        t_fes_out r;
        r.decision_state    = st;
        r.skip_work         = sk;
        r.disable_unit      = ds;
        r.stop_req          = sp;
        r.termination       = tm;
        r.consecutive_count = cn;
        r.overall_state     = ov;
        r.terminal_reason   = rs;
        return r;
    endfunction

    task automatic add_row(input t_cmd cmd, input t_fault code, input t_comp tgt,
                           input logic [TIME_BITS-1:0] now, input bit typed,
                           input t_fes_out want);
        t_row row;
        row.beat.cmd              = cmd;
        row.beat.fault_code       = code;
        row.beat.target_component = tgt;
        row.beat.now_time         = now;
        row.typed                 = typed;
        row.want                  = want;
        plan.push_back(row);
    endtask

    // reports, some repeating the last fault, with recovers, time jumps and odd targets mixed in
    function automatic t_fes_in gen_beat();
        t_fes_in     b;
        int unsigned pick;
        pick = $urandom_range(99);
        case ($urandom_range(19))
            0:       tick = TIME_BITS'({$urandom(), $urandom()});
            1, 2:    tick = tick + TIME_BITS'($urandom_range(20000));
            default: tick = tick + TIME_BITS'($urandom_range(400));
        endcase
        b.now_time         = tick;
        b.fault_code       = CODE_BITS'($urandom_range(15));
        b.target_component = 3'($urandom_range(7));
        if (pick < 62) begin
            b.cmd = CMD_REPORT;
            if ($urandom_range(99) < 40) begin
                b.fault_code = last_code;
            end
            last_code = b.fault_code;
        end else if (pick < 95) begin
            b.cmd              = CMD_RECOVER;
            b.target_component = 3'($urandom_range(COMPONENTS - 1));
        end else begin
            b.cmd = CMD_RECOVER;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("MISMATCH %s on result %0d: got %0h, want %0h", what, n_checked, got, want);
        n_errors++;
    endtask

    task automatic send_beat(input t_fes_in b, input bit typed, input t_fes_out want);
        t_fes_out pred;
        if ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = next_verdict(b);
        verdict_q.push_back(typed ? want : pred);
        n_beats++;
    endtask

    task automatic wait_idle();
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_CAMERA_TIMEOUT: cam_tmo  = val;
            CFG_SINK_TIMEOUT:   sink_tmo = val;
            CFG_EVAL_COUNT:     eval_thr = val[THR_BITS-1:0];
            CFG_DEBUG_COUNT:    dbg_thr  = val[THR_BITS-1:0];
            default: ;
        endcase
    endtask

    // upper bits of the threshold words are junk and must be ignored
    task automatic set_limits(input logic [TMO_BITS-1:0] cam, input logic [TMO_BITS-1:0] sink,
                              input logic [THR_BITS-1:0] ev, input logic [THR_BITS-1:0] dbg);
        write_reg(CFG_CAMERA_TIMEOUT, cam);
        write_reg(CFG_SINK_TIMEOUT, sink);
        write_reg(CFG_EVAL_COUNT, {16'($urandom()), ev});
        write_reg(CFG_DEBUG_COUNT, {16'($urandom()), dbg});
    endtask

    // receiver: random stall, or a long hold-off when asked
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_fes_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with nothing expected", 48'(o_out_data), '0);
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.decision_state != want.decision_state)
                    report_mismatch("decision_state", 48'(o_out_data.decision_state),
                                    48'(want.decision_state));
                if (o_out_data.skip_work != want.skip_work)
                    report_mismatch("skip_work", 48'(o_out_data.skip_work),
                                    48'(want.skip_work));
                if (o_out_data.disable_unit != want.disable_unit)
                    report_mismatch("disable_unit", 48'(o_out_data.disable_unit),
                                    48'(want.disable_unit));
                if (o_out_data.stop_req != want.stop_req)
                    report_mismatch("stop_req", 48'(o_out_data.stop_req),
                                    48'(want.stop_req));
                if (o_out_data.termination != want.termination)
                    report_mismatch("termination", 48'(o_out_data.termination),
                                    48'(want.termination));
                if (o_out_data.consecutive_count != want.consecutive_count)
                    report_mismatch("consecutive_count", 48'(o_out_data.consecutive_count),
                                    48'(want.consecutive_count));
                if (o_out_data.overall_state != want.overall_state)
                    report_mismatch("overall_state", 48'(o_out_data.overall_state),
                                    48'(want.overall_state));
                if (o_out_data.terminal_reason != want.terminal_reason)
                    report_mismatch("terminal_reason", 48'(o_out_data.terminal_reason),
                                    48'(want.terminal_reason));
                if (o_out_data.termination != TERM_NONE) n_terms++;
                if (o_out_data.disable_unit) n_disable++;
            end
            n_checked++;
        end
    end

    initial begin
        #(CYCLE_NS * LIMIT_CYC);
        $display("timeout with %0d results outstanding", verdict_q.size());
        $display("fault_escalation_supervisor test failed");
        $finish;
    end

    initial begin
        // directed table, reset configuration
        add_row(CMD_RECOVER, FC_DIAG_C, COMP_NONE, '1, 1'b1,
                mk_out(H_HEALTHY, 1'b0, 1'b0, 1'b0, TERM_NONE, 32'd0, H_HEALTHY, TERM_NONE));
        add_row(CMD_REPORT, FC_DIAG_A, COMP_CAMERA, '0, 1'b1,
                mk_out(H_DEGRADED, 1'b0, 1'b0, 1'b0, TERM_NONE, 32'd1, H_DEGRADED,
                       TERM_NONE));
        add_row(CMD_REPORT, FC_DIAG_C, COMP_NONE, 48'd1, 1'b0, '0);
        add_row(CMD_RECOVER, FC_CAM_TIMEOUT, COMP_DIAG, '1, 1'b1,
                mk_out(H_HEALTHY, 1'b0, 1'b0, 1'b0, TERM_NONE, 32'd0, H_HEALTHY, TERM_NONE));
        add_row(CMD_REPORT, FC_EVAL_INIT, COMP_DIAG, 48'd10, 1'b1,
                mk_out(H_DEGRADED, 1'b1, 1'b1, 1'b0, TERM_NONE, 32'd1, H_DEGRADED,
                       TERM_NONE));
        add_row(CMD_REPORT, FC_EVAL_EXC, COMP_SINK, 48'd11, 1'b0, '0);
        add_row(CMD_REPORT, FC_EVAL_EXC, COMP_EVAL, 48'd12, 1'b0, '0);
        add_row(CMD_REPORT, FC_EVAL_EXC, COMP_DEBUG, 48'd13, 1'b0, '0);
        add_row(CMD_RECOVER, FC_EVAL_EXC, COMP_EVAL, 48'd14, 1'b0, '0);
        add_row(CMD_REPORT, FC_DEBUG_INIT, COMP_CONTROL, 48'd15, 1'b0, '0);
        add_row(CMD_REPORT, FC_DEBUG_EXC, COMP_PIPELINE, 48'd16, 1'b0, '0);
        add_row(CMD_REPORT, FC_DEBUG_EXC, COMP_NONE, 48'd17, 1'b0, '0);
        add_row(CMD_REPORT, FC_CAM_TIMEOUT, COMP_CAMERA, 48'd100, 1'b0, '0);
        // one tick short of the camera timeout
        add_row(CMD_REPORT, FC_CAM_INVALID, COMP_CAMERA, 48'd1000099, 1'b0, '0);
        add_row(CMD_RECOVER, FC_DIAG_B, COMP_CAMERA, 48'hFFFF_FFFF_FF00, 1'b0, '0);
        // time wraps; elapsed is exactly the timeout
        add_row(CMD_REPORT, FC_CAM_INVALID, COMP_DIAG, 48'd999744, 1'b1,
                mk_out(H_FAILED, 1'b1, 1'b0, 1'b1, TERM_CAMERA, 32'd1, H_FAILED,
                       TERM_CAMERA));
        add_row(CMD_RECOVER, FC_DIAG_A, COMP_CAMERA, '0, 1'b0, '0);
        add_row(CMD_REPORT, FC_SINK_UNHEALTHY, COMP_SINK, '1, 1'b0, '0);
        add_row(CMD_REPORT, FC_SEND_FAILED, COMP_SINK, 48'd999998, 1'b0, '0);
        add_row(CMD_REPORT, FC_SEND_FAILED, COMP_SINK, 48'd999999, 1'b0, '0);
        add_row(CMD_REPORT, FC_PIPE_EXC, COMP_PIPELINE, 48'd5, 1'b0, '0);
        add_row(CMD_REPORT, FC_CTRL_UPDATE_EXC, COMP_CONTROL, 48'd6, 1'b0, '0);
        add_row(CMD_REPORT, FC_CTRL_THREAD_EXC, COMP_CONTROL, 48'd7, 1'b0, '0);
        add_row(CMD_REPORT, FC_CAM_DISCONNECT, COMP_CAMERA, 48'd8, 1'b0, '0);
        add_row(CMD_REPORT, FC_CAM_FATAL, COMP_CAMERA, 48'd9, 1'b0, '0);
        add_row(CMD_REPORT, FC_DIAG_B, COMP_DIAG, 48'h8000_0000_0000, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].want);
        tick = 48'd1000;

        for (int ph = 0; ph < 3; ph++) begin
            i_in_valid <= 1'b0;
            wait_idle();
            case (ph)
                0: begin
                    snd_idle = 24;
                    rcv_idle = 63;
                    set_limits(32'd2000, 32'd5000, 16'd3, 16'd1);
                end
                1: begin
                    snd_idle = 63;
                    rcv_idle = 24;
                    set_limits(32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                    set_limits(32'hFFFF_FFFF, 32'd0, 16'd2, 16'd4);
                end
            endcase
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (ph == 0 && k == 150) hold_reqs++;
                send_beat(gen_beat(), 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch("results never delivered", 48'(verdict_q.size()), '0);

        $display("%0d beats (directed table, three random phases of limits and idling), %0d checked",
                 n_beats, n_checked);
        $display("%0d results terminated, %0d disabled a unit, %0d mismatches",
                 n_terms, n_disable, n_errors);
        if (n_errors == 0) begin
            $display("fault_escalation_supervisor test passed");
        end else begin
            $display("fault_escalation_supervisor test failed");
        end
        $finish;
    end

endmodule
